### sv/pll_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// profile linear/log interpolator. No dependencies.
package pll_pkg;

  localparam int LEVELS    = 64;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int CNT_W     = LVL_W + 1;
  localparam int SQ_STEPS  = 24;
  localparam int SQ_W      = $clog2(SQ_STEPS);
  localparam int DIV_STEPS = 30;
  localparam int DIV_W     = $clog2(DIV_STEPS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_COORD_MODE = 1'b0;
  localparam logic CFG_REL_BASE   = 1'b1;

  typedef enum logic [1:0] {
    LSEL_Q  = 2'd0,
    LSEL_HI = 2'd1,
    LSEL_LO = 2'd2
  } log_sel_t;

  typedef struct packed {
    logic     wr;
    logic     scan_start;
    logic     scan;
    logic     check;
    logic     log_load;
    log_sel_t log_sel;
    logic     log_norm;
    logic     log_sq;
    logic     subs;
    logic     wsetup;
    logic     div_step;
    logic     mul_lo;
    logic     mul_hi;
    logic     mul_add;
    logic     interp;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic chk_final;
    logic chk_log;
    logic norm_done;
    logic sq_done;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

### sv/pll_ctrl.sv
// Sequencing state machine of the interpolator: scan, check, log, subtract,
// weight setup, divide, multiply, interpolate and finish steps. Depends on pll_pkg.
module pll_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  input  pll_pkg::sts_t sts,
  output logic          busy,
  output pll_pkg::cmd_t cmd
);
  import pll_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_SCAN    = 13'b0000000000010,
    S_CHECK   = 13'b0000000000100,
    S_LOGNORM = 13'b0000000001000,
    S_LOGSQ   = 13'b0000000010000,
    S_SUBS    = 13'b0000000100000,
    S_WSETUP  = 13'b0000001000000,
    S_DIV     = 13'b0000010000000,
    S_MULLO   = 13'b0000100000000,
    S_MULHI   = 13'b0001000000000,
    S_MULADD  = 13'b0010000000000,
    S_INTERP  = 13'b0100000000000,
    S_FINISH  = 13'b1000000000000
  } state_t;

  state_t   state, state_next;
  log_sel_t log_sel, log_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      log_sel <= LSEL_Q;
    end else begin
      state   <= state_next;
      log_sel <= log_sel_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    log_sel_next = log_sel;
    cmd          = '0;
    cmd.log_sel  = log_sel;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_QUERY) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_final) begin
          state_next = S_FINISH;
        end else if (sts.chk_log) begin
          cmd.log_load = 1'b1;
          cmd.log_sel  = LSEL_Q;
          log_sel_next = LSEL_Q;
          state_next   = S_LOGNORM;
        end else begin
          state_next = S_SUBS;
        end
      end
      S_LOGNORM: begin
        cmd.log_norm = 1'b1;
        if (sts.norm_done) state_next = S_LOGSQ;
      end
      S_LOGSQ: begin
        cmd.log_sq = 1'b1;
        if (sts.sq_done) begin
          if (log_sel == LSEL_LO) begin
            state_next = S_SUBS;
          end else begin
            log_sel_next = (log_sel == LSEL_Q) ? LSEL_HI : LSEL_LO;
            cmd.log_load = 1'b1;
            cmd.log_sel  = log_sel_next;
            state_next   = S_LOGNORM;
          end
        end
      end
      S_SUBS: begin
        cmd.subs   = 1'b1;
        state_next = S_WSETUP;
      end
      S_WSETUP: begin
        cmd.wsetup = 1'b1;
        state_next = sts.need_div ? S_DIV : S_MULLO;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MULADD;
      end
      S_MULADD: begin
        cmd.mul_add = 1'b1;
        state_next  = S_INTERP;
      end
      S_INTERP: begin
        cmd.interp = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && op == OP_QUERY) |=> (state == S_SCAN))
    else $error("query transfer did not start a scan");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (state == S_IDLE))
    else $error("finish step did not return to idle");

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_done) |=> (state == S_DIV))
    else $error("division left before its last step");

endmodule

### sv/pll_dp.sv
// Datapath of the interpolator: profile memories, present flags, scan
// trackers, log2 unit, divider, multiplier and result register. Uses pll_pkg.
module pll_dp (
  input  logic                clk,
  input  logic                rst,
  input  pll_pkg::cmd_t       cmd,
  output pll_pkg::sts_t       sts,
  input  logic [5:0]          level,
  input  logic signed [31:0]  coord_value,
  input  logic signed [31:0]  data_value,
  input  logic                present,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output logic                done,
  output logic signed [31:0]  result_value,
  output logic                result_valid
);
  import pll_pkg::*;

  logic                    coord_mode, relative_to_base;
  logic signed [31:0]      coord_mem [LEVELS];
  logic signed [31:0]      data_mem  [LEVELS];
  logic [LEVELS-1:0]       flags;
  logic [LVL_W-1:0]        wr_addr;
  logic signed [31:0]      rd_c, rd_d;

  logic [CNT_W-1:0]        scan_addr;
  logic [LVL_W-1:0]        p_k;
  logic                    p_v;
  logic signed [31:0]      q;
  logic                    q_pres;
  logic                    have_bot, lo_active, hi_have;
  logic signed [31:0]      cbot, dbot, ctop, dtop, clo, dlo, chi, dhi;
  logic                    cond_lo;
  logic signed [31:0]      chi_eff, dhi_eff;
  logic                    range_bad, bad, ep_bot, ep_top, log_bad;

  logic [30:0]             lm;
  logic [4:0]              lmsb;
  logic [SQ_STEPS-1:0]     lres, lres_next;
  logic [SQ_W-1:0]         sq_cnt;
  log_sel_t                cur_sel;
  logic signed [31:0]      log_src;
  logic [61:0]             sq;
  logic [31:0]             sq_t;
  logic [28:0]             lq, l0, l1, l_new;

  logic signed [33:0]      num, den, diff;
  logic signed [31:0]      y0;
  logic [34:0]             rem, rem_sh;
  logic [30:0]             w;
  logic [DIV_W-1:0]        div_cnt;
  logic                    dneg;
  logic [32:0]             dmag;
  logic [46:0]             plo;
  logic [47:0]             phi;
  logic [63:0]             acc;
  logic signed [34:0]      qt;
  logic signed [33:0]      r;
  logic                    res_ok;
  logic signed [34:0]      rr;
  logic signed [31:0]      sat;

  assign wr_addr = LVL_W'(level);

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_mode       <= 1'b0;
      relative_to_base <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COORD_MODE: coord_mode       <= cfg_data;
        CFG_REL_BASE:   relative_to_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(level) < 32'(LEVELS))) begin
      coord_mem[wr_addr] <= coord_value;
      data_mem[wr_addr]  <= data_value;
    end
    rd_c <= coord_mem[scan_addr[LVL_W-1:0]];
    rd_d <= data_mem[scan_addr[LVL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.wr && (32'(level) < 32'(LEVELS))) begin
      flags[wr_addr] <= present;
    end
  end

  assign cond_lo = coord_mode ? (rd_c > q) : (rd_c <= q);
  assign sts.scan_done = p_v && (p_k == LVL_W'(LEVELS - 1));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
      p_v       <= 1'b0;
      have_bot  <= 1'b0;
      lo_active <= 1'b1;
      hi_have   <= 1'b0;
      q         <= coord_value;
      q_pres    <= present;
    end else if (cmd.scan) begin
      scan_addr <= scan_addr + 1'b1;
      p_v       <= (32'(scan_addr) < 32'(LEVELS));
      p_k       <= scan_addr[LVL_W-1:0];
      if (p_v && flags[p_k]) begin
        if (!have_bot) begin
          have_bot <= 1'b1;
          cbot     <= rd_c;
          dbot     <= rd_d;
        end
        ctop <= rd_c;
        dtop <= rd_d;
        if (lo_active) begin
          if (cond_lo || !have_bot) begin
            clo <= rd_c;
            dlo <= rd_d;
          end
          if (!cond_lo) begin
            lo_active <= 1'b0;
          end
        end
        if (cond_lo) begin
          hi_have <= 1'b0;
        end else if (!hi_have) begin
          hi_have <= 1'b1;
          chi     <= rd_c;
          dhi     <= rd_d;
        end
      end
    end else if (cmd.check) begin
      chi <= chi_eff;
      dhi <= dhi_eff;
    end
  end

  assign chi_eff   = hi_have ? chi : ctop;
  assign dhi_eff   = hi_have ? dhi : dtop;
  assign range_bad = coord_mode ? ((q > cbot) || (q < ctop)) : ((q < cbot) || (q > ctop));
  assign bad       = !q_pres || !have_bot || range_bad;
  assign ep_bot    = (q == cbot);
  assign ep_top    = (q == ctop);
  assign log_bad   = coord_mode && ((q <= 0) || (chi_eff <= 0) || (clo <= 0));
  assign sts.chk_final = bad || ep_bot || ep_top || log_bad;
  assign sts.chk_log   = coord_mode;

  always_comb begin
    unique case (cmd.log_sel)
      LSEL_Q:  log_src = q;
      LSEL_HI: log_src = chi;
      LSEL_LO: log_src = clo;
      default: log_src = q;
    endcase
  end

  assign sts.norm_done = lm[30] || (lmsb == 5'd0);
  assign sq        = {31'b0, lm} * {31'b0, lm};
  assign sq_t      = sq[61:30];
  assign lres_next = {lres[SQ_STEPS-2:0], sq_t[31]};
  assign l_new     = {lmsb, lres_next};
  assign sts.sq_done = (sq_cnt == SQ_W'(SQ_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      lm      <= log_src[30:0];
      lmsb    <= 5'd30;
      lres    <= '0;
      sq_cnt  <= '0;
      cur_sel <= cmd.log_sel;
    end else if (cmd.log_norm) begin
      if (!sts.norm_done) begin
        lm   <= {lm[29:0], 1'b0};
        lmsb <= lmsb - 5'd1;
      end
    end else if (cmd.log_sq) begin
      lm     <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      lres   <= lres_next;
      sq_cnt <= sq_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.log_sq) begin
      unique case (cur_sel)
        LSEL_Q:  lq <= l_new;
        LSEL_HI: l0 <= l_new;
        LSEL_LO: l1 <= l_new;
        default: lq <= l_new;
      endcase
    end
  end

  assign sts.need_div = !((den <= 0) || (num < 0)) && (num < den);
  assign sts.div_done = (div_cnt == DIV_W'(DIV_STEPS - 1));
  assign rem_sh       = {rem[33:0], 1'b0};
  assign qt           = $signed({1'b0, acc[63:30]});

  always_ff @(posedge clk) begin
    if (cmd.subs) begin
      if (!coord_mode) begin
        num  <= 34'(q) - 34'(clo);
        den  <= 34'(chi) - 34'(clo);
        diff <= 34'(dhi) - 34'(dlo);
        y0   <= dlo;
      end else begin
        num  <= $signed({5'b0, lq}) - $signed({5'b0, l0});
        den  <= $signed({5'b0, l1}) - $signed({5'b0, l0});
        diff <= 34'(dlo) - 34'(dhi);
        y0   <= dhi;
      end
    end
    if (cmd.wsetup) begin
      dneg    <= diff[33];
      dmag    <= diff[33] ? 33'(-diff) : diff[32:0];
      rem     <= {1'b0, num};
      div_cnt <= '0;
      if ((den <= 0) || (num < 0)) begin
        w <= '0;
      end else if (num >= den) begin
        w <= 31'h4000_0000;
      end else begin
        w <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        w   <= {w[29:0], 1'b1};
      end else begin
        rem <= rem_sh;
        w   <= {w[29:0], 1'b0};
      end
    end
    if (cmd.mul_lo)  plo <= {31'b0, dmag[15:0]} * {16'b0, w};
    if (cmd.mul_hi)  phi <= {31'b0, dmag[32:16]} * {17'b0, w};
    if (cmd.mul_add) acc <= {17'b0, plo} + {phi, 16'b0};
  end

  assign rr  = 35'(r) - (relative_to_base ? 35'(dbot) : 35'sd0);
  assign sat = (rr > 35'sd2147483647)  ? 32'sh7fff_ffff :
               (rr < -35'sd2147483648) ? 32'sh8000_0000 : rr[31:0];

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_ok <= !bad && (ep_bot || ep_top || !log_bad);
      r      <= ep_bot ? 34'(dbot) : 34'(dtop);
    end else if (cmd.interp) begin
      r <= 34'(35'(y0) + (dneg ? -qt : qt));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      result_value <= res_ok ? sat : 32'sd0;
      result_valid <= res_ok;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result_valid) |-> (result_value == 32'sd0))
    else $error("invalid result carries a nonzero value");

  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_lo |-> (w <= 31'h4000_0000))
    else $error("weight above one");

endmodule

### sv/profile_linear_log_interpolator.sv
// Top level of the profile interpolator: joins the controller and datapath.
// Depends on pll_pkg, pll_ctrl and pll_dp.
//
// Usage: an item is transferred at a clock edge where start is high and busy
// is low. A write item (op 0) stores one level in that same cycle, produces
// no result and leaves busy low, so writes may follow every cycle. A query
// item (op 1) raises busy until its result is delivered. The result appears
// on result_value and result_valid for exactly one cycle with done high; the
// receiver cannot stall it. Configuration writes use cfg_write, cfg_index and
// cfg_data and take effect at the same edge; issue them only while idle.
// A query scans all 64 stored levels through the memory read port, then,
// when the numerator is non-negative and below a positive denominator, runs
// a 30-step restoring divider, and then a split multiply. In log mode three
// base-2 logarithms are taken first, each a normalizing shift of up to 30
// bit positions plus 24 squaring steps. Endpoint matches and invalid queries
// finish right after the scan and its check step. Reset clears the present
// flags and the configuration registers and needs no clearing pass.
module profile_linear_log_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [5:0]         level,
  input  logic signed [31:0] coord_value,
  input  logic signed [31:0] data_value,
  input  logic               present,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic               cfg_data,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               result_valid
);
  import pll_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  pll_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .level        (level),
    .coord_value  (coord_value),
    .data_value   (data_value),
    .present      (present),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .result_value (result_value),
    .result_valid (result_valid)
  );

endmodule

### tb/profile_linear_log_interpolator_tb.sv
// Self-checking testbench for profile_linear_log_interpolator: directed table
// then constrained-by-hand random profiles and queries, checked by a predictor.
// Depends on pll_pkg and the RTL of the interpolator.
module profile_linear_log_interpolator_tb;
  import pll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, start, op, present, cfg_write, cfg_index, cfg_data;
  logic [5:0] level;
  logic signed [31:0] coord_value, data_value;
  logic busy, done, result_valid;
  logic signed [31:0] result_value;

  profile_linear_log_interpolator dut (.*);

  typedef struct {
    logic signed [31:0] value;
    logic               valid;
  } interp_t;

  logic signed [31:0] prof_coord [LEVELS];
  logic signed [31:0] prof_data [LEVELS];
  logic               prof_here [LEVELS];
  logic               mode_log, mode_rel;
  interp_t            pending_q[$];
  int                 errors, shown;
  int                 send_idle;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint log2_q24(logic signed [31:0] v);
    logic [31:0] u;
    int top;
    longint unsigned m;
    longint acc;
    u = v;
    top = 30;
    while (top > 0 && u[top] == 1'b0) top--;
    m = longint'(u) << (30 - top);
    acc = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      acc = acc << 1;
      if (m >= (64'd1 << 31)) begin
        acc = acc | 1;
        m = m >> 1;
      end
    end
    return (longint'(top) << 24) + acc;
  endfunction

  function automatic longint blend_weight(longint num, longint den);
    longint w;
    if (den <= 0) return 0;
    if (num < 0) num = 0;
    if (num >= den) return 64'sd1 << 30;
    w = (num * (64'sd1 << 30)) / den;
    return w;
  endfunction

  function automatic interp_t interpolate(logic signed [31:0] q);
    interp_t res;
    int kb, kt, lo, hi;
    longint y0, y1, w, r;
    res.value = 0;
    res.valid = 0;
    kb = -1;
    kt = -1;
    for (int k = 0; k < LEVELS; k++) begin
      if (prof_here[k]) begin
        if (kb < 0) kb = k;
        kt = k;
      end
    end
    if (kb < 0) return res;
    if (!mode_log && (q < prof_coord[kb] || q > prof_coord[kt])) return res;
    if (mode_log && (q > prof_coord[kb] || q < prof_coord[kt])) return res;
    if (q == prof_coord[kb]) r = prof_data[kb];
    else if (q == prof_coord[kt]) r = prof_data[kt];
    else begin
      lo = kb;
      for (int k = kb; k <= kt; k++) begin
        if (!prof_here[k]) continue;
        if (mode_log ? (prof_coord[k] > q) : (prof_coord[k] <= q)) lo = k;
        else break;
      end
      hi = kt;
      for (int k = kt; k >= kb; k--) begin
        if (!prof_here[k]) continue;
        if (mode_log ? (prof_coord[k] <= q) : (prof_coord[k] > q)) hi = k;
        else break;
      end
      if (!mode_log) begin
        y0 = prof_data[lo];
        y1 = prof_data[hi];
        w = blend_weight(longint'(q) - prof_coord[lo],
                         longint'(prof_coord[hi]) - prof_coord[lo]);
      end else begin
        if (q <= 0 || prof_coord[hi] <= 0 || prof_coord[lo] <= 0) return res;
        y0 = prof_data[hi];
        y1 = prof_data[lo];
        w = blend_weight(log2_q24(q) - log2_q24(prof_coord[hi]),
                         log2_q24(prof_coord[lo]) - log2_q24(prof_coord[hi]));
      end
      r = y0 + ((y1 - y0) * w) / (64'sd1 << 30);
    end
    if (mode_rel) begin
      r = r - prof_data[kb];
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
    end
    res.value = r[31:0];
    res.valid = 1;
    return res;
  endfunction

  // Result side: every strobe is a transfer; compare with the oldest expectation.
  always @(posedge clk) begin
    interp_t exp_r;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result value=%0d valid=%0d", result_value, result_valid);
        end
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.value !== result_value || exp_r.valid !== result_valid) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected value=%0d valid=%0d, got value=%0d valid=%0d",
                     exp_r.value, exp_r.valid, result_value, result_valid);
          end
        end
      end
    end
  end

  task automatic send(logic o, logic [5:0] lv, logic signed [31:0] c,
                      logic signed [31:0] d, logic p, logic chk, interp_t typed);
    interp_t e;
    while ($urandom_range(99) < send_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    op <= o;
    level <= lv;
    coord_value <= c;
    data_value <= d;
    present <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (o == OP_WRITE) begin
      prof_coord[lv] = c;
      prof_data[lv] = d;
      prof_here[lv] = p;
    end else begin
      e = p ? interpolate(c) : interp_t'{value: 0, valid: 0};
      if (chk) e = typed;
      pending_q.push_back(e);
    end
  endtask

  task automatic set_mode(logic lg, logic rel);
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_write <= 1;
    cfg_index <= CFG_COORD_MODE;
    cfg_data <= lg;
    @(posedge clk);
    cfg_index <= CFG_REL_BASE;
    cfg_data <= rel;
    @(posedge clk);
    cfg_write <= 0;
    mode_log = lg;
    mode_rel = rel;
  endtask

  typedef struct {
    logic o;
    logic [5:0] lv;
    logic signed [31:0] c, d;
    logic p, typed;
    interp_t r;
  } row_t;

  row_t rows[] = '{
    '{OP_QUERY, 0, 0, 0, 1, 1, '{0, 0}},
    '{OP_QUERY, 0, 0, 0, 0, 1, '{0, 0}},
    '{OP_WRITE, 0, 32'sh0001_0000, 32'sh7fff_ffff, 1, 0, '{0, 0}},
    '{OP_QUERY, 0, 32'sh0001_0000, 0, 1, 1, '{32'sh7fff_ffff, 1}},
    '{OP_QUERY, 0, 32'sh0002_0000, 0, 1, 1, '{0, 0}},
    '{OP_WRITE, 63, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0, '{0, 0}},
    '{OP_QUERY, 0, 32'sh7fff_ffff, 0, 1, 1, '{32'sh8000_0000, 1}},
    '{OP_QUERY, 0, 32'sh4000_0000, 0, 1, 0, '{0, 0}},
    '{OP_WRITE, 30, 32'sh0100_0000, 32'sh0000_1234, 0, 0, '{0, 0}},
    '{OP_WRITE, 31, 32'sh0200_0000, 32'sh0005_0000, 1, 0, '{0, 0}},
    '{OP_QUERY, 0, 32'sh0180_0000, 0, 1, 0, '{0, 0}},
    '{OP_QUERY, 0, 32'sh8000_0000, 0, 1, 1, '{0, 0}},
    '{OP_QUERY, 0, 32'sh0180_0000, 0, 0, 1, '{0, 0}}
  };

  initial begin
    logic signed [31:0] c;
    int nlev, step;
    errors = 0;
    shown = 0;
    send_idle = 27;
    start = 0; op = 0; level = 0; coord_value = 0; data_value = 0; present = 0;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    mode_log = 0;
    mode_rel = 0;
    foreach (prof_here[k]) begin
      prof_here[k] = 0;
      prof_coord[k] = 0;
      prof_data[k] = 0;
    end
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i])
      send(rows[i].o, rows[i].lv, rows[i].c, rows[i].d, rows[i].p, rows[i].typed, rows[i].r);
    set_mode(1, 1);
    send(OP_WRITE, 0, 32'sh03e8_0000, 32'sh8000_0000, 1, 0, '{0, 0});
    send(OP_WRITE, 5, 32'sh0064_0000, 32'sh7fff_ffff, 1, 0, '{0, 0});
    send(OP_WRITE, 63, -32'sd5, 0, 0, 0, '{0, 0});
    send(OP_QUERY, 0, 32'sh01f4_0000, 0, 1, 0, '{0, 0});
    send(OP_QUERY, 0, 32'sh0064_0000, 0, 1, 0, '{0, 0});
    for (int phase = 0; phase < 8; phase++) begin
      send_idle = (phase < 3) ? 27 : (phase < 6 ? 45 : 0);
      set_mode(phase[0], phase[1] ^ phase[2]);
      foreach (prof_here[k])
        if (prof_here[k]) send(OP_WRITE, 6'(k), 0, 0, 0, 0, '{0, 0});
      nlev = (phase == 7) ? 64 : $urandom_range(1, 12);
      c = mode_log ? $urandom_range(32'h7000_0000, 32'h1000_0000) : $urandom;
      if (!mode_log && c > 32'sh4000_0000) c = c - 32'sh6000_0000;
      for (int k = 0; k < nlev; k++) begin
        step = $urandom_range(1, 32'h0800_0000 / nlev);
        send(OP_WRITE, 6'(k + (phase == 7 ? 0 : $urandom_range(0, 8))), c, $urandom,
             $urandom_range(9) != 0, 0, '{0, 0});
        c = mode_log ? c - step : c + step;
        if (mode_log && c <= 0) c = 1;
      end
      repeat (30) begin
        if ($urandom_range(9) == 0)
          send(OP_WRITE, 6'($urandom), $urandom, $urandom, 1'($urandom), 0, '{0, 0});
        else begin
          if ($urandom_range(5) == 0) c = $urandom;
          else c = c + (mode_log ? 1 : -1) * $urandom_range(0, 32'h0900_0000);
          send(OP_QUERY, 6'($urandom), c, $urandom, $urandom_range(15) != 0, 0, '{0, 0});
        end
      end
    end
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### files.f
sv/pll_pkg.sv
sv/pll_ctrl.sv
sv/pll_dp.sv
sv/profile_linear_log_interpolator.sv
tb/profile_linear_log_interpolator_tb.sv
